### hw/rtl/smz_pkg.sv
// ----------------------------------------------------------------------------
// smz_pkg: shared constants for the small motion zeroing block
// Field widths of the threshold registers, register indexes and fixed-point
// alignment used by the compare stages.
// ----------------------------------------------------------------------------
`default_nettype none

package smz_pkg;

  // default widths of the item fields
  localparam int COMP_BITS_DEF   = 24;
  localparam int RADIUS_BITS_DEF = 16;

  // threshold register widths
  localparam int ACC_W  = 48;
  localparam int STEP_W = 32;

  // split point of acc_crit_sq for the partial products
  localparam int ACC_LO = 24;

  // fraction bits added to squares so both sides of a compare line up
  localparam int FRAC_ALIGN = 16;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = ACC_W;
  localparam logic [CFG_IDX_W-1:0] CFG_ACC_CRIT_SQ = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SQ     = 1'd1;

  // command codes
  localparam logic CMD_TRANS = 1'b0;
  localparam logic CMD_ROT   = 1'b1;

endpackage

`default_nettype wire

### hw/rtl/smz_in_if.sv
// ----------------------------------------------------------------------------
// smz_in_if: input item channel
// Valid/ready channel carrying one particle's rate, change and radius.
// ----------------------------------------------------------------------------
`default_nettype none

interface smz_in_if #(
  parameter int COMP_BITS   = smz_pkg::COMP_BITS_DEF,
  parameter int RADIUS_BITS = smz_pkg::RADIUS_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic signed [COMP_BITS-1:0]   rate_x;
  logic signed [COMP_BITS-1:0]   rate_y;
  logic signed [COMP_BITS-1:0]   rate_z;
  logic signed [COMP_BITS-1:0]   change_x;
  logic signed [COMP_BITS-1:0]   change_y;
  logic signed [COMP_BITS-1:0]   change_z;
  logic        [RADIUS_BITS-1:0] radius;

  modport source (
    output valid, command, rate_x, rate_y, rate_z,
    output change_x, change_y, change_z, radius,
    input  ready
  );

  modport sink (
    input  valid, command, rate_x, rate_y, rate_z,
    input  change_x, change_y, change_z, radius,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/smz_out_if.sv
// ----------------------------------------------------------------------------
// smz_out_if: result item channel
// Valid/ready channel carrying the tested vectors and the two status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface smz_out_if #(
  parameter int COMP_BITS = smz_pkg::COMP_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [COMP_BITS-1:0] new_rate_x;
  logic signed [COMP_BITS-1:0] new_rate_y;
  logic signed [COMP_BITS-1:0] new_rate_z;
  logic signed [COMP_BITS-1:0] new_change_x;
  logic signed [COMP_BITS-1:0] new_change_y;
  logic signed [COMP_BITS-1:0] new_change_z;
  logic                        was_zeroed;
  logic                        radius_fault;

  modport source (
    output valid, new_rate_x, new_rate_y, new_rate_z,
    output new_change_x, new_change_y, new_change_z, was_zeroed, radius_fault,
    input  ready
  );

  modport sink (
    input  valid, new_rate_x, new_rate_y, new_rate_z,
    input  new_change_x, new_change_y, new_change_z, was_zeroed, radius_fault,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/smz_split_mul.sv
// ----------------------------------------------------------------------------
// smz_split_mul: unsigned multiply as four partial products
// Splits both operands into a low and a high part and returns the four
// partial products; the caller registers them and adds them up a stage later.
// ----------------------------------------------------------------------------
`default_nettype none

module smz_split_mul #(
  parameter int A_W  = 48,
  parameter int B_W  = 32,
  parameter int A_LO = 24,
  parameter int B_LO = 16
) (
  input  wire logic [A_W-1:0]                   a,
  input  wire logic [B_W-1:0]                   b,
  output logic      [A_LO+B_LO-1:0]             p00,
  output logic      [A_LO+(B_W-B_LO)-1:0]       p01,
  output logic      [(A_W-A_LO)+B_LO-1:0]       p10,
  output logic      [(A_W-A_LO)+(B_W-B_LO)-1:0] p11
);

  localparam int A_HI = A_W - A_LO;
  localparam int B_HI = B_W - B_LO;

  logic [A_LO-1:0] a_lo;
  logic [A_HI-1:0] a_hi;
  logic [B_LO-1:0] b_lo;
  logic [B_HI-1:0] b_hi;

  // operand halves
  assign a_lo = a[A_LO-1:0];
  assign a_hi = a[A_W-1:A_LO];
  assign b_lo = b[B_LO-1:0];
  assign b_hi = b[B_W-1:B_LO];

  // partial products, weights 0, B_LO, A_LO and A_LO+B_LO
  assign p00 = (A_LO+B_LO)'(a_lo) * (A_LO+B_LO)'(b_lo);
  assign p01 = (A_LO+B_HI)'(a_lo) * (A_LO+B_HI)'(b_hi);
  assign p10 = (A_HI+B_LO)'(a_hi) * (A_HI+B_LO)'(b_lo);
  assign p11 = (A_HI+B_HI)'(a_hi) * (A_HI+B_HI)'(b_hi);

endmodule

`default_nettype wire

### hw/rtl/small_motion_zeroing_core.sv
// ----------------------------------------------------------------------------
// small_motion_zeroing_core: zeroes the motion of a particle coming to rest
// Tests rate and change vectors against the critical thresholds and returns
// both vectors zeroed when the particle is slowing down below them.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one particle per item: command (0 translational, 1
//   rotational), rate and change vectors and the radius. rsp returns one
//   result item per input item, in order, with the vectors either passed
//   through or zeroed, plus was_zeroed and radius_fault. The user writes
//   acc_crit_sq (index 0) and step_sq (index 1) only while no item is in
//   flight, via cfg_we/cfg_index/cfg_data; the core does not enforce it.
// Timing:
//   four register stages (products, sums, compare setup, output register);
//   an item goes through them in that order and shows on rsp once it
//   is in the output register. The multiplier stages are fully pipelined,
//   so one item is accepted every cycle while ready is high.
//   Each stage has its own valid bit and takes a new item whenever it is
//   empty or the stage after it moves, so bubbles fill up while rsp stalls;
//   ready drops only when all four stages hold items and rsp stalls.
// Reset:
//   rst clears all stage valid bits and both threshold registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module small_motion_zeroing_core #(
  parameter int COMP_BITS   = smz_pkg::COMP_BITS_DEF,
  parameter int RADIUS_BITS = smz_pkg::RADIUS_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [smz_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [smz_pkg::CFG_DATA_W-1:0]   cfg_data,
  smz_in_if.sink                                req,
  smz_out_if.source                             rsp
);

  localparam int C         = COMP_BITS;
  localparam int R         = RADIUS_BITS;
  localparam int ACC_W     = smz_pkg::ACC_W;
  localparam int STEP_W    = smz_pkg::STEP_W;
  localparam int ACC_LO    = smz_pkg::ACC_LO;
  localparam int ACC_HI    = ACC_W - ACC_LO;
  localparam int PROD_W    = 2 * C;
  localparam int DOT_W     = 2 * C + 2;
  localparam int SQ_W      = 2 * C;
  localparam int RAD2_W    = 2 * R;
  localparam int LS_W      = ACC_LO + STEP_W;
  localparam int LSH_W     = ACC_HI + STEP_W;
  localparam int LIM_W     = ACC_W + STEP_W;
  localparam int ACCRAD_W  = ACC_W + RAD2_W;
  localparam int RR_W      = SQ_W + RAD2_W;
  localparam int ALIGN_W   = SQ_W + smz_pkg::FRAC_ALIGN;
  localparam int MAX_A     = (LIM_W > ACCRAD_W) ? LIM_W : ACCRAD_W;
  localparam int MAX_B     = (RR_W > ALIGN_W) ? RR_W : ALIGN_W;
  localparam int CMP_W     = (MAX_A > MAX_B) ? MAX_A : MAX_B;
  // partial product widths of the two split multipliers
  localparam int AR00_W    = ACC_LO + R;
  localparam int AR01_W    = ACC_LO + (RAD2_W - R);
  localparam int AR10_W    = ACC_HI + R;
  localparam int AR11_W    = ACC_HI + (RAD2_W - R);
  localparam int RR00_W    = C + R;
  localparam int RR01_W    = C + (RAD2_W - R);
  localparam int RR10_W    = (SQ_W - C) + R;
  localparam int RR11_W    = (SQ_W - C) + (RAD2_W - R);

  // threshold registers
  logic [ACC_W-1:0]  acc_crit_sq;
  logic [STEP_W-1:0] step_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_crit_sq <= '0;
      step_sq     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        smz_pkg::CFG_ACC_CRIT_SQ: acc_crit_sq <= cfg_data[ACC_W-1:0];
        smz_pkg::CFG_STEP_SQ:     step_sq     <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when empty or when the next one moves
  logic s1_v, s2_v, s3_v, o_v;
  logic en1, en2, en3, en_o;

  assign en_o      = !o_v || rsp.ready;
  assign en3       = !s3_v || en_o;
  assign en2       = !s2_v || en3;
  assign en1       = !s1_v || en2;
  assign req.ready = en1;

  // ---------------- stage 1: component products ----------------
  logic signed [C-1:0] in_rate [3];
  logic signed [C-1:0] in_chg  [3];

  assign in_rate[0] = req.rate_x;
  assign in_rate[1] = req.rate_y;
  assign in_rate[2] = req.rate_z;
  assign in_chg[0]  = req.change_x;
  assign in_chg[1]  = req.change_y;
  assign in_chg[2]  = req.change_z;

  logic signed [PROD_W-1:0] s1_d    [3];
  logic        [PROD_W-1:0] s1_cc   [3];
  logic        [PROD_W-1:0] s1_rr   [3];
  logic signed [C-1:0]      s1_rate [3];
  logic signed [C-1:0]      s1_chg  [3];
  logic                     s1_rot;
  logic                     s1_rzero;
  logic [RAD2_W-1:0]        s1_rad2;
  logic [LS_W-1:0]          s1_ls0;
  logic [LSH_W-1:0]         s1_ls1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en1) begin
      s1_v <= req.valid;
    end
  end

  // products of each component pair, radius squared, threshold product halves
  always_ff @(posedge clk) begin
    if (en1) begin
      for (int i = 0; i < 3; i++) begin
        s1_d[i]    <= PROD_W'(in_rate[i]) * PROD_W'(in_chg[i]);
        s1_cc[i]   <= $unsigned(PROD_W'(in_chg[i]) * PROD_W'(in_chg[i]));
        s1_rr[i]   <= $unsigned(PROD_W'(in_rate[i]) * PROD_W'(in_rate[i]));
        s1_rate[i] <= in_rate[i];
        s1_chg[i]  <= in_chg[i];
      end
      s1_rot   <= (req.command == smz_pkg::CMD_ROT);
      s1_rzero <= (req.radius == '0);
      s1_rad2  <= RAD2_W'(req.radius) * RAD2_W'(req.radius);
      s1_ls0   <= LS_W'(acc_crit_sq[ACC_LO-1:0]) * LS_W'(step_sq);
      s1_ls1   <= LSH_W'(acc_crit_sq[ACC_W-1:ACC_LO]) * LSH_W'(step_sq);
    end
  end

  // ---------------- stage 2: sums, acc x radius^2 partials ----------------
  logic signed [DOT_W-1:0] dot_sum;
  logic [SQ_W-1:0]         c2_sum;
  logic [SQ_W-1:0]         r2_sum;
  logic [LIM_W-1:0]        lim_sum;

  assign dot_sum = DOT_W'(s1_d[0]) + DOT_W'(s1_d[1]) + DOT_W'(s1_d[2]);
  assign c2_sum  = s1_cc[0] + s1_cc[1] + s1_cc[2];
  assign r2_sum  = s1_rr[0] + s1_rr[1] + s1_rr[2];
  assign lim_sum = LIM_W'(s1_ls0) + (LIM_W'(s1_ls1) << ACC_LO);

  logic [AR00_W-1:0] ar00;
  logic [AR01_W-1:0] ar01;
  logic [AR10_W-1:0] ar10;
  logic [AR11_W-1:0] ar11;

  smz_split_mul #(
    .A_W  (ACC_W),
    .B_W  (RAD2_W),
    .A_LO (ACC_LO),
    .B_LO (R)
  ) u_acc_rad (
    .a   (acc_crit_sq),
    .b   (s1_rad2),
    .p00 (ar00),
    .p01 (ar01),
    .p10 (ar10),
    .p11 (ar11)
  );

  logic signed [C-1:0] s2_rate [3];
  logic signed [C-1:0] s2_chg  [3];
  logic                s2_rot;
  logic                s2_rzero;
  logic                s2_dneg;
  logic [SQ_W-1:0]     s2_c2;
  logic [SQ_W-1:0]     s2_r2v;
  logic [RAD2_W-1:0]   s2_rad2;
  logic [LIM_W-1:0]    s2_lim;
  logic [AR00_W-1:0]   s2_ar00;
  logic [AR01_W-1:0]   s2_ar01;
  logic [AR10_W-1:0]   s2_ar10;
  logic [AR11_W-1:0]   s2_ar11;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en2) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_rate  <= s1_rate;
      s2_chg   <= s1_chg;
      s2_rot   <= s1_rot;
      s2_rzero <= s1_rzero;
      s2_dneg  <= dot_sum[DOT_W-1];
      s2_c2    <= c2_sum;
      s2_r2v   <= r2_sum;
      s2_rad2  <= s1_rad2;
      s2_lim   <= lim_sum;
      s2_ar00  <= ar00;
      s2_ar01  <= ar01;
      s2_ar10  <= ar10;
      s2_ar11  <= ar11;
    end
  end

  // ---------------- stage 3: change test, rate x radius^2 partials ----------------
  logic [ACCRAD_W-1:0] accrad;
  logic                c_ok;

  assign accrad = ACCRAD_W'(s2_ar00)
                + (ACCRAD_W'(s2_ar01) << R)
                + (ACCRAD_W'(s2_ar10) << ACC_LO)
                + (ACCRAD_W'(s2_ar11) << (ACC_LO + R));

  // rotational threshold is scaled by radius squared
  always_comb begin
    if (s2_rot) begin
      c_ok = (CMP_W'(s2_c2) << smz_pkg::FRAC_ALIGN) < CMP_W'(accrad);
    end else begin
      c_ok = CMP_W'(s2_c2) < CMP_W'(acc_crit_sq);
    end
  end

  logic [RR00_W-1:0] rr00;
  logic [RR01_W-1:0] rr01;
  logic [RR10_W-1:0] rr10;
  logic [RR11_W-1:0] rr11;

  smz_split_mul #(
    .A_W  (SQ_W),
    .B_W  (RAD2_W),
    .A_LO (C),
    .B_LO (R)
  ) u_rate_rad (
    .a   (s2_r2v),
    .b   (s2_rad2),
    .p00 (rr00),
    .p01 (rr01),
    .p10 (rr10),
    .p11 (rr11)
  );

  logic signed [C-1:0] s3_rate [3];
  logic signed [C-1:0] s3_chg  [3];
  logic                s3_rot;
  logic                s3_rzero;
  logic                s3_dneg;
  logic                s3_c_ok;
  logic                s3_c2nz;
  logic                s3_r2nz;
  logic [SQ_W-1:0]     s3_r2v;
  logic [LIM_W-1:0]    s3_lim;
  logic [RR00_W-1:0]   s3_rr00;
  logic [RR01_W-1:0]   s3_rr01;
  logic [RR10_W-1:0]   s3_rr10;
  logic [RR11_W-1:0]   s3_rr11;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en3) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_rate  <= s2_rate;
      s3_chg   <= s2_chg;
      s3_rot   <= s2_rot;
      s3_rzero <= s2_rzero;
      s3_dneg  <= s2_dneg;
      s3_c_ok  <= c_ok;
      s3_c2nz  <= (s2_c2 != '0);
      s3_r2nz  <= (s2_r2v != '0);
      s3_r2v   <= s2_r2v;
      s3_lim   <= s2_lim;
      s3_rr00  <= rr00;
      s3_rr01  <= rr01;
      s3_rr10  <= rr10;
      s3_rr11  <= rr11;
    end
  end

  // ---------------- stage 4: rate test, decision, output register ----------------
  logic [RR_W-1:0] rr_sum;
  logic            r_ok;
  logic            fault;
  logic            zero;

  assign rr_sum = RR_W'(s3_rr00)
                + (RR_W'(s3_rr01) << R)
                + (RR_W'(s3_rr10) << C)
                + (RR_W'(s3_rr11) << (C + R));

  always_comb begin
    if (s3_rot) begin
      r_ok = CMP_W'(rr_sum) < CMP_W'(s3_lim);
    end else begin
      r_ok = (CMP_W'(s3_r2v) << smz_pkg::FRAC_ALIGN) < CMP_W'(s3_lim);
    end
  end

  // zero radius on a rotational item blocks the test and flags a fault
  assign fault = s3_rot && s3_rzero;
  assign zero  = !fault && s3_dneg && s3_c2nz && s3_r2nz && s3_c_ok && r_ok;

  logic signed [C-1:0] o_rate [3];
  logic signed [C-1:0] o_chg  [3];
  logic                o_zero;
  logic                o_fault;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (en_o) begin
      o_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      for (int i = 0; i < 3; i++) begin
        o_rate[i] <= zero ? '0 : s3_rate[i];
        o_chg[i]  <= zero ? '0 : s3_chg[i];
      end
      o_zero  <= zero;
      o_fault <= fault;
    end
  end

  assign rsp.valid        = o_v;
  assign rsp.new_rate_x   = o_rate[0];
  assign rsp.new_rate_y   = o_rate[1];
  assign rsp.new_rate_z   = o_rate[2];
  assign rsp.new_change_x = o_chg[0];
  assign rsp.new_change_y = o_chg[1];
  assign rsp.new_change_z = o_chg[2];
  assign rsp.was_zeroed   = o_zero;
  assign rsp.radius_fault = o_fault;

  // ---------------- assertions ----------------
  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !o_v)
    else $error("output valid right after reset");

  // a faulted item is never zeroed
  a_fault_excl: assert property (@(posedge clk) disable iff (rst)
    o_v |-> !(o_zero && o_fault))
    else $error("item both zeroed and faulted");

  // a blocked stage 3 keeps its item
  a_stage3_hold: assert property (@(posedge clk) disable iff (rst)
    (s3_v && !en3) |=> (s3_v && $stable(s3_r2v) && $stable(s3_c_ok)))
    else $error("stage 3 item lost under stall");

  // the output stage, draining with nothing behind it, goes empty
  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    (o_v && rsp.ready && !s3_v) |=> !o_v)
    else $error("result repeated after drain");

endmodule

`default_nettype wire

### test/tb_small_motion_zeroing_core.sv
// ----------------------------------------------------------------------------
// tb_small_motion_zeroing_core: testbench for the small motion zeroing core
// Streams particles through the core under several threshold settings and
// checks every result against an in-bench predictor of the rest test. The
// items are directed corner cases, near-rest particles and raw noise. Both
// channels idle in random bursts, and the result side holds off once for a
// long stretch so that the core fills up and stalls its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_small_motion_zeroing_core;

  localparam int CW = smz_pkg::COMP_BITS_DEF;
  localparam int RW = smz_pkg::RADIUS_BITS_DEF;

  // comp[0..2] rate x/y/z, comp[3..5] change x/y/z
  typedef struct packed {
    logic                cmd;
    logic [5:0][CW-1:0]  comp;
    logic [RW-1:0]       radius;
  } motion_item_t;

  typedef struct packed {
    logic [5:0][CW-1:0]  vec;
    logic                zeroed;
    logic                fault;
  } motion_result_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [smz_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [smz_pkg::CFG_DATA_W-1:0] cfg_data;

  smz_in_if  #(.COMP_BITS(CW), .RADIUS_BITS(RW)) req_ch ();
  smz_out_if #(.COMP_BITS(CW))                   rsp_ch ();

  small_motion_zeroing_core #(
    .COMP_BITS   (CW),
    .RADIUS_BITS (RW)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // threshold copies as the core holds them
  logic [smz_pkg::ACC_W-1:0]  acc_sq;
  logic [smz_pkg::STEP_W-1:0] step_sq;

  motion_item_t   particles_to_send[$];
  motion_result_t rest_results_due[$];
  motion_item_t   offered;
  bit             sending;
  bit             item_taken;
  int             send_gap;
  int             send_idle_pct;
  int             sink_idle_pct;
  int             stall_left;
  int             hold_left;
  int             holds_asked;
  int             holds_served;
  int             results_seen;
  int             mismatches;

  string vec_names [6] = '{"new_rate_x", "new_rate_y", "new_rate_z",
                           "new_change_x", "new_change_y", "new_change_z"};

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // prints one mismatch line and counts it
  task automatic report_mismatch(string msg);
    $display("ERROR: result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  // expected outcome of the rest test for one particle
  function automatic motion_result_t predict_rest(motion_item_t it);
    motion_result_t res;
    longint         rv, cv, dot;
    longint unsigned c2, r2;
    logic [31:0]    rad2;
    logic [127:0]   lim_rate;
    bit             zero, fault;
    dot = 0;
    c2 = 0;
    r2 = 0;
    zero = 1'b0;
    for (int i = 0; i < 3; i++) begin
      rv = $signed(it.comp[i]);
      cv = $signed(it.comp[3+i]);
      dot += rv * cv;
      c2 += cv * cv;
      r2 += rv * rv;
    end
    fault = (it.cmd == smz_pkg::CMD_ROT) && (it.radius == '0);
    if (!fault && dot < 0 && c2 > 0 && r2 > 0) begin
      lim_rate = 128'(acc_sq) * 128'(step_sq);
      if (it.cmd == smz_pkg::CMD_TRANS) begin
        zero = (c2 < acc_sq) && ((128'(r2) << smz_pkg::FRAC_ALIGN) < lim_rate);
      end else begin
        rad2 = it.radius * it.radius;
        zero = ((128'(c2) << smz_pkg::FRAC_ALIGN) < 128'(acc_sq) * 128'(rad2)) &&
               (128'(r2) * 128'(rad2) < lim_rate);
      end
    end
    res.vec = zero ? '0 : it.comp;
    res.zeroed = zero;
    res.fault = fault;
    return res;
  endfunction

  function automatic motion_item_t motion(logic cmd, int rx, int ry, int rz,
                                          int cx, int cy, int cz, int rad);
    motion_item_t it;
    it.cmd = cmd;
    it.comp[0] = CW'(rx);
    it.comp[1] = CW'(ry);
    it.comp[2] = CW'(rz);
    it.comp[3] = CW'(cx);
    it.comp[4] = CW'(cy);
    it.comp[5] = CW'(cz);
    it.radius = RW'(rad);
    return it;
  endfunction

  // signed component with magnitude below 2^bits
  function automatic logic [CW-1:0] rand_comp(int bits, bit neg);
    int mag;
    mag = $urandom_range(0, (1 << bits) - 1);
    return neg ? CW'(-mag) : CW'(mag);
  endfunction

  // mostly particles slowing down at random scales, some raw noise
  function automatic motion_item_t random_motion();
    motion_item_t it;
    int           e_rate, e_chg;
    bit           rneg;
    it.cmd = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) == 0) it.radius = '0;
    else it.radius = RW'($urandom & ((1 << $urandom_range(1, RW)) - 1));
    if ($urandom_range(0, 3) == 0) begin
      for (int i = 0; i < 6; i++) it.comp[i] = CW'($urandom);
    end else begin
      e_rate = $urandom_range(0, CW - 1);
      e_chg = $urandom_range(0, CW - 1);
      for (int i = 0; i < 3; i++) begin
        rneg = 1'($urandom_range(0, 1));
        it.comp[i] = rand_comp(e_rate, rneg);
        it.comp[3+i] = rand_comp(e_chg, ($urandom_range(0, 7) == 0) ? rneg : !rneg);
      end
    end
    return it;
  endfunction

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) particles_to_send.push_back(random_motion());
  endtask

  // waits until no item is queued, offered or in flight
  task automatic wait_idle();
    do @(negedge clk);
    while (particles_to_send.size() != 0 || sending || rest_results_due.size() != 0);
  endtask

  // one register write; the caller drops the write enable afterwards
  task automatic write_threshold(logic [smz_pkg::CFG_IDX_W-1:0] idx,
                                 logic [smz_pkg::CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    if (idx == smz_pkg::CFG_ACC_CRIT_SQ) acc_sq = value;
    else step_sq = value[smz_pkg::STEP_W-1:0];
  endtask

  // new thresholds once the core has drained, new idling odds
  task automatic set_thresholds(logic [smz_pkg::ACC_W-1:0] acc,
                                logic [smz_pkg::STEP_W-1:0] step, bit quiet);
    wait_idle();
    write_threshold(smz_pkg::CFG_ACC_CRIT_SQ, acc);
    write_threshold(smz_pkg::CFG_STEP_SQ, {16'($urandom), step});
    cfg_we <= 1'b0;
    send_idle_pct = quiet ? 0 : $urandom_range(0, 2) * 10;
    sink_idle_pct = quiet ? 0 : $urandom_range(0, 2) * 10;
  endtask

  // corner cases, run with acc 2^40 and step 2^16
  task automatic queue_directed();
    particles_to_send.push_back(motion(smz_pkg::CMD_TRANS, 0, 0, 0, 0, 0, 0, 0));
    particles_to_send.push_back(motion(smz_pkg::CMD_TRANS, 4096, -4096, 100,
                                       -4096, 4096, -100, 0));
    particles_to_send.push_back(motion(smz_pkg::CMD_TRANS, 4096, -4096, 100,
                                       -4096, 4096, -100, 65535));
    particles_to_send.push_back(motion(smz_pkg::CMD_ROT, 4096, -4096, 100,
                                       -4096, 4096, -100, 0));
    particles_to_send.push_back(motion(smz_pkg::CMD_ROT, 4096, -4096, 100,
                                       -4096, 4096, -100, 256));
    particles_to_send.push_back(motion(smz_pkg::CMD_ROT, 4096, -4096, 100,
                                       -4096, 4096, -100, 65535));
    particles_to_send.push_back(motion(smz_pkg::CMD_ROT, 4096, -4096, 100,
                                       -4096, 4096, -100, 1));
    // full-scale components
    particles_to_send.push_back(motion(smz_pkg::CMD_TRANS, -8388608, -8388608, -8388608,
                                       8388607, 8388607, 8388607, 0));
    particles_to_send.push_back(motion(smz_pkg::CMD_TRANS, 8388607, 8388607, 8388607,
                                       -8388608, -8388608, -8388608, 65535));
    particles_to_send.push_back(motion(smz_pkg::CMD_ROT, -8388608, -8388608, -8388608,
                                       -8388608, -8388608, -8388608, 65535));
    // change magnitude on and just below the threshold
    particles_to_send.push_back(motion(smz_pkg::CMD_TRANS, -1, 0, 0, 1 << 20, 0, 0, 0));
    particles_to_send.push_back(motion(smz_pkg::CMD_TRANS, -1, 0, 0,
                                       (1 << 20) - 1, 0, 0, 0));
    particles_to_send.push_back(motion(smz_pkg::CMD_ROT, -1, 0, 0, 1 << 20, 0, 0, 256));
    particles_to_send.push_back(motion(smz_pkg::CMD_ROT, -1, 0, 0,
                                       (1 << 20) - 1, 0, 0, 256));
    // rate magnitude on and just below the threshold
    particles_to_send.push_back(motion(smz_pkg::CMD_TRANS, 1 << 20, 0, 0, -1, 0, 0, 0));
    particles_to_send.push_back(motion(smz_pkg::CMD_TRANS, (1 << 20) - 1, 0, 0,
                                       -1, 0, 0, 0));
    // one vector zero, dot product zero, dot product just negative
    particles_to_send.push_back(motion(smz_pkg::CMD_TRANS, 5, 5, 5, 0, 0, 0, 0));
    particles_to_send.push_back(motion(smz_pkg::CMD_ROT, 0, 0, 0, -5, 5, -5, 256));
    particles_to_send.push_back(motion(smz_pkg::CMD_TRANS, 1, 0, 0, 0, 1, 0, 0));
    particles_to_send.push_back(motion(smz_pkg::CMD_TRANS, 3, 2, 0, -1, 1, 0, 0));
  endtask

  // acceptance on the item side and the expected result
  always @(posedge clk) begin
    item_taken = !rst && req_ch.valid && req_ch.ready;
    if (item_taken) rest_results_due.push_back(predict_rest(offered));
  end

  // item driver
  always @(negedge clk) begin
    if (rst) begin
      sending = 1'b0;
      req_ch.valid <= 1'b0;
    end else begin
      if (item_taken) sending = 1'b0;
      if (!sending) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (particles_to_send.size() != 0) begin
          offered = particles_to_send.pop_front();
          sending = 1'b1;
          req_ch.command <= offered.cmd;
          req_ch.rate_x <= offered.comp[0];
          req_ch.rate_y <= offered.comp[1];
          req_ch.rate_z <= offered.comp[2];
          req_ch.change_x <= offered.comp[3];
          req_ch.change_y <= offered.comp[4];
          req_ch.change_z <= offered.comp[5];
          req_ch.radius <= offered.radius;
          if ($urandom_range(0, 99) < send_idle_pct) send_gap = $urandom_range(1, 19);
        end
      end
      req_ch.valid <= sending;
    end
  end

  // result side ready: long hold-off on request, else random stall bursts
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (holds_served != holds_asked) begin
        holds_served = holds_asked;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < sink_idle_pct) stall_left = $urandom_range(1, 19);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    motion_result_t got, want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.vec[0] = rsp_ch.new_rate_x;
      got.vec[1] = rsp_ch.new_rate_y;
      got.vec[2] = rsp_ch.new_rate_z;
      got.vec[3] = rsp_ch.new_change_x;
      got.vec[4] = rsp_ch.new_change_y;
      got.vec[5] = rsp_ch.new_change_z;
      got.zeroed = rsp_ch.was_zeroed;
      got.fault = rsp_ch.radius_fault;
      if (rest_results_due.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        want = rest_results_due.pop_front();
        for (int i = 0; i < 6; i++) begin
          if (got.vec[i] !== want.vec[i])
            report_mismatch($sformatf("%s got %h expected %h",
                                      vec_names[i], got.vec[i], want.vec[i]));
        end
        if (got.zeroed !== want.zeroed)
          report_mismatch($sformatf("was_zeroed got %b expected %b", got.zeroed, want.zeroed));
        if (got.fault !== want.fault)
          report_mismatch($sformatf("radius_fault got %b expected %b", got.fault, want.fault));
      end
      results_seen++;
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // stimulus sequence
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.command = smz_pkg::CMD_TRANS;
    req_ch.rate_x = '0;
    req_ch.rate_y = '0;
    req_ch.rate_z = '0;
    req_ch.change_x = '0;
    req_ch.change_y = '0;
    req_ch.change_z = '0;
    req_ch.radius = '0;
    rsp_ch.ready = 1'b0;
    acc_sq = '0;
    step_sq = '0;
    sending = 1'b0;
    item_taken = 1'b0;
    send_gap = 0;
    stall_left = 0;
    hold_left = 0;
    holds_asked = 0;
    holds_served = 0;
    results_seen = 0;
    mismatches = 0;
    send_idle_pct = 10;
    sink_idle_pct = 10;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // thresholds still at reset: nothing may be zeroed
    queue_random(40);

    set_thresholds(48'd1 << 40, 32'd1 << 16, 1'b0);
    queue_directed();
    queue_random(250);
    holds_asked++;

    set_thresholds({smz_pkg::ACC_W{1'b1}}, {smz_pkg::STEP_W{1'b1}}, 1'b0);
    queue_random(250);

    set_thresholds(48'd1 << 36, 32'd1 << 8, 1'b0);
    queue_random(250);

    set_thresholds(smz_pkg::ACC_W'({$urandom, $urandom}) >>
                     $urandom_range(0, smz_pkg::ACC_W - 1),
                   $urandom >> $urandom_range(0, smz_pkg::STEP_W - 1), 1'b0);
    queue_random(250);

    set_thresholds('0, {smz_pkg::STEP_W{1'b1}}, 1'b0);
    queue_random(100);

    set_thresholds(48'd1 << 44, '0, 1'b0);
    queue_random(100);

    // closing stretch without idling
    set_thresholds(48'd1 << 40, 32'd1 << 16, 1'b1);
    queue_random(150);

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
